>>> rtl/bip_buffer_region_manager_unit_macros.svh
// ----------------------------------------------------------------------------
// Bip buffer region manager: assertion macros
// Shared concurrent assertion forms, clocked and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef BIP_BUFFER_REGION_MANAGER_UNIT_MACROS_SVH
`define BIP_BUFFER_REGION_MANAGER_UNIT_MACROS_SVH

// same-cycle implication
`define BBRM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bbrm: same-cycle check failed");

// next-cycle implication
`define BBRM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bbrm: next-cycle check failed");

`endif

>>> rtl/bbrm_pkg.sv
// ----------------------------------------------------------------------------
// Bip buffer region manager: package
// Request action codes shared by the top level and the region core.
// ----------------------------------------------------------------------------
package bbrm_pkg;

    localparam int ACTION_W = 2;

    typedef enum logic [ACTION_W-1:0] {
        ACT_CHECK  = 2'd0,
        ACT_COMMIT = 2'd1,
        ACT_REMOVE = 2'd2,
        ACT_CLEAR  = 2'd3
    } action_t;

endpackage

>>> rtl/bbrm_core.sv
// ----------------------------------------------------------------------------
// Bip buffer region manager: region core
// Holds the region pointers, applies one request per step and derives the
// pointer report from the updated state.
// ----------------------------------------------------------------------------
module bbrm_core #(
    parameter int CAPACITY = 4096,
    parameter int CNT_W    = 13,
    parameter int OFS_W    = 12
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  step,
    input  bbrm_pkg::action_t     action,
    input  logic [CNT_W-1:0]      length,
    output logic [CNT_W-1:0]      free_space,
    output logic [CNT_W-1:0]      write_offset,
    output logic [OFS_W-1:0]      read_offset,
    output logic [CNT_W-1:0]      contiguous_count,
    output logic [CNT_W-1:0]      stored_count,
    output logic                  overflow_flag,
    output logic                  move_needed,
    output logic [OFS_W-1:0]      move_from,
    output logic [CNT_W-1:0]      move_count
);
    import bbrm_pkg::*;

    localparam int SUM_W = CNT_W + 1;
    localparam logic [SUM_W-1:0] CAP_V = SUM_W'(CAPACITY);

    logic [OFS_W-1:0] pstart_reg, pstart_next;
    logic [CNT_W-1:0] pcount_reg, pcount_next;
    logic             sopen_reg,  sopen_next;
    logic [CNT_W-1:0] scount_reg, scount_next;

    logic [SUM_W-1:0] pend;
    logic [SUM_W-1:0] space_after;
    logic [CNT_W-1:0] room;
    logic [CNT_W-1:0] len_clamped;
    logic [CNT_W-1:0] take_p;
    logic [CNT_W-1:0] rest;
    logic [CNT_W-1:0] take_s;

    logic [SUM_W-1:0] n_pend;
    logic [SUM_W-1:0] n_after;
    logic [CNT_W-1:0] n_gap;
    logic [SUM_W-1:0] n_total;

    // free room of the region being written, on the current state
    always_comb
    begin
        pend        = SUM_W'(pstart_reg) + SUM_W'(pcount_reg);
        space_after = (CAP_V > pend) ? (CAP_V - pend) : '0;
        if (sopen_reg)
        begin
            room = (CNT_W'(pstart_reg) > scount_reg) ?
                   (CNT_W'(pstart_reg) - scount_reg) : '0;
        end
        else
        begin
            room = space_after[CNT_W-1:0];
        end
        len_clamped = (length > room) ? room : length;
        take_p      = (length > pcount_reg) ? pcount_reg : length;
        rest        = length - take_p;
        take_s      = (rest > scount_reg) ? scount_reg : rest;
    end

    always_comb
    begin
        pstart_next   = pstart_reg;
        pcount_next   = pcount_reg;
        sopen_next    = sopen_reg;
        scount_next   = scount_reg;
        overflow_flag = 1'b0;
        move_needed   = 1'b0;
        move_from     = '0;
        move_count    = '0;
        unique case (action)
            ACT_CHECK:
            begin
                // open the wrap region when the gap in front is the larger one
                if (!sopen_reg && (SUM_W'(pstart_reg) > space_after))
                begin
                    sopen_next  = 1'b1;
                    scount_next = '0;
                end
            end
            ACT_COMMIT:
            begin
                overflow_flag = (length > room);
                if (sopen_reg)
                begin
                    scount_next = scount_reg + len_clamped;
                end
                else
                begin
                    pcount_next = pcount_reg + len_clamped;
                end
            end
            ACT_REMOVE:
            begin
                pcount_next = pcount_reg - take_p;
                pstart_next = pstart_reg + OFS_W'(take_p);
                scount_next = scount_reg - take_s;
                if (pcount_next == '0)
                begin
                    if (scount_next != '0)
                    begin
                        // leftover wrap data becomes primary; copy only if its head moved
                        if (take_s != '0)
                        begin
                            move_needed = 1'b1;
                            move_from   = OFS_W'(take_s);
                            move_count  = scount_next;
                        end
                        pstart_next = '0;
                        pcount_next = scount_next;
                        sopen_next  = 1'b0;
                        scount_next = '0;
                    end
                    else
                    begin
                        pstart_next = '0;
                        pcount_next = '0;
                        sopen_next  = 1'b0;
                        scount_next = '0;
                    end
                end
            end
            default:
            begin
                pstart_next = '0;
                pcount_next = '0;
                sopen_next  = 1'b0;
                scount_next = '0;
            end
        endcase
    end

    // report on the updated pointers
    always_comb
    begin
        n_pend  = SUM_W'(pstart_next) + SUM_W'(pcount_next);
        n_after = (CAP_V > n_pend) ? (CAP_V - n_pend) : '0;
        n_gap   = (CNT_W'(pstart_next) > scount_next) ?
                  (CNT_W'(pstart_next) - scount_next) : '0;
        n_total = SUM_W'(pcount_next) + SUM_W'(scount_next);

        free_space       = sopen_next ? n_gap : n_after[CNT_W-1:0];
        write_offset     = sopen_next ? scount_next : n_pend[CNT_W-1:0];
        read_offset      = (pcount_next != '0) ? pstart_next : '0;
        contiguous_count = (pcount_next != '0) ? pcount_next : scount_next;
        stored_count     = n_total[CNT_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pstart_reg <= '0;
            pcount_reg <= '0;
            sopen_reg  <= 1'b0;
            scount_reg <= '0;
        end
        else if (step)
        begin
            pstart_reg <= pstart_next;
            pcount_reg <= pcount_next;
            sopen_reg  <= sopen_next;
            scount_reg <= scount_next;
        end
    end

endmodule

>>> rtl/bip_buffer_region_manager_unit.sv
// ----------------------------------------------------------------------------
// Bip buffer region manager unit
// Offset bookkeeping for a two-region byte buffer: free-space check, commit,
// remove with compaction request, and clear.
//
//   channel   dir  tdata fields (low bit first)
//   s_axis    in   action, length
//   m_axis    out  free_space, write_offset, read_offset, contiguous_count,
//                  stored_count, overflow_flag, move_needed, move_from,
//                  move_count
//
// One request per cycle sustained while m_axis takes results; an accepted
// request passes the input register, then the result register.
// The pointer update sits in one combinational step between the two
// registers, so back-to-back requests see each other's state updates.
// Reset clears all pointers and empties both stages; stage data is not reset.
// A stalled m_axis holds the result and lets one more request enter the
// input register before s_axis_tready drops.
// ----------------------------------------------------------------------------
`include "bip_buffer_region_manager_unit_macros.svh"

module bip_buffer_region_manager_unit #(
    parameter int CAPACITY = 4096
) (
    input  logic clk,
    input  logic rst_n,
    input  logic s_axis_tvalid,
    output logic s_axis_tready,
    // action, length
    input  logic [((bbrm_pkg::ACTION_W + $clog2(CAPACITY + 1) + 7) / 8) * 8 - 1:0]
                 s_axis_tdata,
    output logic m_axis_tvalid,
    input  logic m_axis_tready,
    // free_space, write_offset, read_offset, contiguous_count, stored_count,
    // overflow_flag, move_needed, move_from, move_count
    output logic [((5 * $clog2(CAPACITY + 1) + 2 * $clog2(CAPACITY) + 2 + 7) / 8) * 8 - 1:0]
                 m_axis_tdata
);
    import bbrm_pkg::*;

    localparam int CNT_W   = $clog2(CAPACITY + 1);
    localparam int OFS_W   = $clog2(CAPACITY);
    localparam int IN_W    = ACTION_W + CNT_W;
    localparam int IN_TW   = ((IN_W + 7) / 8) * 8;
    localparam int OUT_W   = 5 * CNT_W + 2 * OFS_W + 2;
    localparam int OUT_TW  = ((OUT_W + 7) / 8) * 8;

    logic               in_valid_reg, in_valid_next;
    action_t            in_action_reg, in_action_next;
    logic [CNT_W-1:0]   in_length_reg, in_length_next;
    logic               out_valid_reg, out_valid_next;
    logic [OUT_W-1:0]   out_data_reg, out_data_next;

    logic               advance;
    logic               step;

    logic [CNT_W-1:0]   c_free;
    logic [CNT_W-1:0]   c_wr;
    logic [OFS_W-1:0]   c_rd;
    logic [CNT_W-1:0]   c_contig;
    logic [CNT_W-1:0]   c_stored;
    logic               c_ovf;
    logic               c_mv;
    logic [OFS_W-1:0]   c_mv_from;
    logic [CNT_W-1:0]   c_mv_cnt;

    logic               out_overflow;
    logic               out_move_needed;
    logic [CNT_W-1:0]   out_move_count;
    logic [CNT_W-1:0]   out_contiguous;
    logic [CNT_W-1:0]   out_stored;

    assign advance       = !out_valid_reg || m_axis_tready;
    assign step          = in_valid_reg && advance;
    assign s_axis_tready = !in_valid_reg || advance;

    bbrm_core #(
        .CAPACITY (CAPACITY),
        .CNT_W    (CNT_W),
        .OFS_W    (OFS_W)
    ) u_core (
        .clk              (clk),
        .rst_n            (rst_n),
        .step             (step),
        .action           (in_action_reg),
        .length           (in_length_reg),
        .free_space       (c_free),
        .write_offset     (c_wr),
        .read_offset      (c_rd),
        .contiguous_count (c_contig),
        .stored_count     (c_stored),
        .overflow_flag    (c_ovf),
        .move_needed      (c_mv),
        .move_from        (c_mv_from),
        .move_count       (c_mv_cnt)
    );

    always_comb
    begin
        in_valid_next  = in_valid_reg;
        in_action_next = in_action_reg;
        in_length_next = in_length_reg;
        if (s_axis_tready)
        begin
            in_valid_next = s_axis_tvalid;
            if (s_axis_tvalid)
            begin
                in_action_next = action_t'(s_axis_tdata[ACTION_W-1:0]);
                in_length_next = s_axis_tdata[IN_W-1:ACTION_W];
            end
        end

        out_valid_next = advance ? in_valid_reg : out_valid_reg;
        out_data_next  = step ? {c_mv_cnt, c_mv_from, c_mv, c_ovf, c_stored,
                                 c_contig, c_rd, c_wr, c_free}
                              : out_data_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        in_action_reg <= in_action_next;
        in_length_reg <= in_length_next;
        out_data_reg  <= out_data_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_TW'(out_data_reg);

    assign out_contiguous  = out_data_reg[3*CNT_W+OFS_W-1 -: CNT_W];
    assign out_stored      = out_data_reg[4*CNT_W+OFS_W-1 -: CNT_W];
    assign out_overflow    = out_data_reg[4*CNT_W+OFS_W];
    assign out_move_needed = out_data_reg[4*CNT_W+OFS_W+1];
    assign out_move_count  = out_data_reg[OUT_W-1 -: CNT_W];

    // a compaction request always carries bytes to move
    `BBRM_ASSERT_NOW(a_move_has_count, clk, rst_n, m_axis_tvalid && out_move_needed, out_move_count != '0)
    // clamp flag and compaction come from different actions
    `BBRM_ASSERT_NOW(a_flags_exclusive, clk, rst_n, m_axis_tvalid, !(out_overflow && out_move_needed))
    `BBRM_ASSERT_NOW(a_contig_le_stored, clk, rst_n, m_axis_tvalid, out_contiguous <= out_stored)
    // a request that steps the core shows up as a result next cycle
    `BBRM_ASSERT_NEXT(a_step_loads_result, clk, rst_n, step, m_axis_tvalid)

endmodule
